### rtl/core/cau_pkg.sv
// ---------------------------------------------------------------------------
// cau_pkg
// Shared types and codes for the complex arithmetic unit.
// ---------------------------------------------------------------------------
package cau_pkg;

  // Width of every operand and result field on the ports
  localparam int FLD_W = 32;
  localparam int CMD_W = 2;

  // Operation codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  // One result word
  typedef struct packed {
    logic [FLD_W-1:0] res_real;
    logic [FLD_W-1:0] res_imag;
    logic             overflow;
    logic             div_zero;
  } res_t;

  // Per-stage sideband that travels down the pipe with each word
  typedef struct packed {
    logic vld;
    logic is_div;   // word still needs the divider result
    logic neg_re;   // sign of the real numerator
    logic neg_im;   // sign of the imaginary numerator
    res_t res;      // finished result for words that skip the divider
  } tag_t;

endpackage

### rtl/core/cau_if.sv
// ---------------------------------------------------------------------------
// cau_in_if / cau_out_if
// Valid/ready channels for operand words and result words.
// ---------------------------------------------------------------------------
interface cau_in_if;
  logic                              valid;
  logic                              ready;
  logic [cau_pkg::CMD_W-1:0]         cmd;
  logic signed [cau_pkg::FLD_W-1:0]  a_real;
  logic signed [cau_pkg::FLD_W-1:0]  a_imag;
  logic signed [cau_pkg::FLD_W-1:0]  b_real;
  logic signed [cau_pkg::FLD_W-1:0]  b_imag;

  modport source (output valid, cmd, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, cmd, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cau_pkg::FLD_W-1:0]  res_real;
  logic signed [cau_pkg::FLD_W-1:0]  res_imag;
  logic                              overflow;
  logic                              div_zero;

  modport source (output valid, res_real, res_imag, overflow, div_zero, input ready);
  modport sink   (input valid, res_real, res_imag, overflow, div_zero, output ready);
endinterface

### rtl/core/cau_front.sv
// ---------------------------------------------------------------------------
// cau_front
// Three pipeline stages: products and add/sub; sums, |B|^2 and add/sub
// saturate; then mul shift/saturate and numerator magnitudes for divide.
// ---------------------------------------------------------------------------
module cau_front #(
  parameter int OPW       = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  cau_pkg::cmd_t            cmd,
  input  logic signed [OPW-1:0]    ar,
  input  logic signed [OPW-1:0]    ai,
  input  logic signed [OPW-1:0]    br,
  input  logic signed [OPW-1:0]    bi,
  output cau_pkg::tag_t            tag,
  output logic [2*OPW-1:0]         mag_re,
  output logic [2*OPW-1:0]         mag_im,
  output logic [2*OPW-1:0]         den
);

  localparam int PW = 2 * OPW;
  localparam int W1 = PW + 1;
  localparam int FW = cau_pkg::FLD_W;

  // Stage 1: products and add/sub
  logic                  s1_vld_r;
  cau_pkg::cmd_t         s1_cmd_r;
  logic signed [PW-1:0]  p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_b2r_r, p_b2i_r;
  logic signed [OPW:0]   as_re_r, as_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd_r <= cmd;
      p_rr_r   <= PW'(ar) * PW'(br);
      p_ii_r   <= PW'(ai) * PW'(bi);
      p_ri_r   <= PW'(ar) * PW'(bi);
      p_ir_r   <= PW'(ai) * PW'(br);
      p_b2r_r  <= PW'(br) * PW'(br);
      p_b2i_r  <= PW'(bi) * PW'(bi);
      if (cmd == cau_pkg::CMD_SUB) begin
        as_re_r <= (OPW+1)'(ar) - (OPW+1)'(br);
        as_im_r <= (OPW+1)'(ai) - (OPW+1)'(bi);
      end else begin
        as_re_r <= (OPW+1)'(ar) + (OPW+1)'(br);
        as_im_r <= (OPW+1)'(ai) + (OPW+1)'(bi);
      end
    end
  end

  // Stage 2: complex sums, divisor |B|^2, saturate add/sub
  logic                  s2_vld_r;
  cau_pkg::cmd_t         s2_cmd_r;
  logic signed [W1-1:0]  s2_re_r, s2_im_r;
  logic [PW-1:0]         s2_den_r;
  cau_pkg::res_t         s2_res_r;
  logic signed [W1-1:0]  re_nxt, im_nxt;
  logic [PW-1:0]         den_nxt;
  cau_pkg::res_t         as_res_nxt;
  logic                  as_fit_re, as_fit_im;
  logic signed [OPW-1:0] as_v_re, as_v_im;

  always_comb begin
    if (s1_cmd_r == cau_pkg::CMD_MUL) begin
      re_nxt = W1'(p_rr_r) - W1'(p_ii_r);
      im_nxt = W1'(p_ri_r) + W1'(p_ir_r);
    end else begin
      // divide: A times conjugate of B
      re_nxt = W1'(p_rr_r) + W1'(p_ii_r);
      im_nxt = W1'(p_ir_r) - W1'(p_ri_r);
    end
    den_nxt = PW'($unsigned(p_b2r_r)) + PW'($unsigned(p_b2i_r));

    as_fit_re = (as_re_r[OPW] == as_re_r[OPW-1]);
    as_fit_im = (as_im_r[OPW] == as_im_r[OPW-1]);
    as_v_re   = as_fit_re ? as_re_r[OPW-1:0]
                          : {as_re_r[OPW], {(OPW-1){~as_re_r[OPW]}}};
    as_v_im   = as_fit_im ? as_im_r[OPW-1:0]
                          : {as_im_r[OPW], {(OPW-1){~as_im_r[OPW]}}};
    as_res_nxt.res_real = FW'(as_v_re);
    as_res_nxt.res_imag = FW'(as_v_im);
    as_res_nxt.overflow = ~as_fit_re | ~as_fit_im;
    as_res_nxt.div_zero = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_cmd_r <= s1_cmd_r;
      s2_re_r  <= re_nxt;
      s2_im_r  <= im_nxt;
      s2_den_r <= den_nxt;
      s2_res_r <= as_res_nxt;
    end
  end

  // Stage 3: mul shift/saturate, numerator magnitudes, zero divisor
  cau_pkg::tag_t         tag_r, tag_nxt;
  logic [PW-1:0]         mag_re_r, mag_im_r, den_r;
  logic signed [W1-1:0]  sh_re, sh_im;
  logic                  mul_fit_re, mul_fit_im, dz;
  logic signed [OPW-1:0] mul_v_re, mul_v_im;
  cau_pkg::res_t         mul_res;

  always_comb begin
    sh_re      = s2_re_r >>> FRAC_BITS;
    sh_im      = s2_im_r >>> FRAC_BITS;
    mul_fit_re = (&sh_re[PW:OPW-1]) | ~(|sh_re[PW:OPW-1]);
    mul_fit_im = (&sh_im[PW:OPW-1]) | ~(|sh_im[PW:OPW-1]);
    mul_v_re   = mul_fit_re ? sh_re[OPW-1:0] : {sh_re[PW], {(OPW-1){~sh_re[PW]}}};
    mul_v_im   = mul_fit_im ? sh_im[OPW-1:0] : {sh_im[PW], {(OPW-1){~sh_im[PW]}}};
    mul_res.res_real = FW'(mul_v_re);
    mul_res.res_imag = FW'(mul_v_im);
    mul_res.overflow = ~mul_fit_re | ~mul_fit_im;
    mul_res.div_zero = 1'b0;

    dz = (s2_cmd_r == cau_pkg::CMD_DIV) && (s2_den_r == '0);

    tag_nxt.vld    = s2_vld_r;
    tag_nxt.is_div = (s2_cmd_r == cau_pkg::CMD_DIV) && !dz;
    tag_nxt.neg_re = s2_re_r[PW];
    tag_nxt.neg_im = s2_im_r[PW];
    case (s2_cmd_r)
      cau_pkg::CMD_ADD,
      cau_pkg::CMD_SUB: tag_nxt.res = s2_res_r;
      cau_pkg::CMD_MUL: tag_nxt.res = mul_res;
      default: begin
        // zero divisor gives zero parts and the flag
        tag_nxt.res          = '0;
        tag_nxt.res.div_zero = dz;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else if (en) begin
      tag_r.vld <= tag_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r.is_div <= tag_nxt.is_div;
      tag_r.neg_re <= tag_nxt.neg_re;
      tag_r.neg_im <= tag_nxt.neg_im;
      tag_r.res    <= tag_nxt.res;
      mag_re_r     <= s2_re_r[PW] ? PW'(-s2_re_r) : PW'(s2_re_r);
      mag_im_r     <= s2_im_r[PW] ? PW'(-s2_im_r) : PW'(s2_im_r);
      den_r        <= s2_den_r;
    end
  end

  assign tag    = tag_r;
  assign mag_re = mag_re_r;
  assign mag_im = mag_im_r;
  assign den    = den_r;

endmodule

### rtl/core/cau_div_step.sv
// ---------------------------------------------------------------------------
// cau_div_step
// One restoring-division stage: brings in one dividend bit, produces one
// quotient bit. Dividend tail and quotient share one shift register.
// ---------------------------------------------------------------------------
module cau_div_step #(
  parameter int OPW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [2*OPW-1:0]     den,
  input  logic [2*OPW-1:0]     p,
  input  logic [OPW:0]         lq,
  output logic [2*OPW-1:0]     p_out,
  output logic [OPW:0]         lq_out
);

  localparam int PW = 2 * OPW;
  localparam int K  = OPW + 1;

  logic [PW:0]   t, diff;
  logic          ge;
  logic [PW-1:0] p_r, p_nxt;
  logic [K-1:0]  lq_r, lq_nxt;

  // trial subtract
  always_comb begin
    t      = {p, lq[K-1]};
    diff   = t - {1'b0, den};
    ge     = (t >= {1'b0, den});
    p_nxt  = ge ? diff[PW-1:0] : t[PW-1:0];
    lq_nxt = {lq[K-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r  <= p_nxt;
      lq_r <= lq_nxt;
    end
  end

  assign p_out  = p_r;
  assign lq_out = lq_r;

endmodule

### rtl/core/cau_divider.sv
// ---------------------------------------------------------------------------
// cau_divider
// Pipelined fixed-point divider for both parts: a range check stage, then
// one quotient bit per stage, OPW+1 bits in all.
// ---------------------------------------------------------------------------
module cau_divider #(
  parameter int OPW       = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  cau_pkg::tag_t        tag_in,
  input  logic [2*OPW-1:0]     mag_re,
  input  logic [2*OPW-1:0]     mag_im,
  input  logic [2*OPW-1:0]     den,
  output cau_pkg::tag_t        tag_out,
  output logic [OPW:0]         q_re,
  output logic [OPW:0]         q_im,
  output logic                 big_re,
  output logic                 big_im
);

  localparam int PW = 2 * OPW;
  localparam int K  = OPW + 1;
  localparam int NW = PW + FRAC_BITS;

  cau_pkg::tag_t tag_p [K+1];
  logic [PW-1:0] den_p [K+1];
  logic          big_re_p [K+1];
  logic          big_im_p [K+1];
  logic [PW-1:0] p_re [K+1];
  logic [PW-1:0] p_im [K+1];
  logic [K-1:0]  lq_re [K+1];
  logic [K-1:0]  lq_im [K+1];

  // Range check: quotient at or above 2^K saturates in any case
  logic [NW-1:0] num_re, num_im, hi_re, hi_im;

  always_comb begin
    num_re = NW'(mag_re) << FRAC_BITS;
    num_im = NW'(mag_im) << FRAC_BITS;
    hi_re  = num_re >> K;
    hi_im  = num_im >> K;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_p[0].vld <= 1'b0;
    end else if (en) begin
      tag_p[0].vld <= tag_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_p[0].is_div <= tag_in.is_div;
      tag_p[0].neg_re <= tag_in.neg_re;
      tag_p[0].neg_im <= tag_in.neg_im;
      tag_p[0].res    <= tag_in.res;
      den_p[0]        <= den;
      big_re_p[0]     <= (hi_re >= NW'(den));
      big_im_p[0]     <= (hi_im >= NW'(den));
      p_re[0]         <= hi_re[PW-1:0];
      p_im[0]         <= hi_im[PW-1:0];
      lq_re[0]        <= num_re[K-1:0];
      lq_im[0]        <= num_im[K-1:0];
    end
  end

  // Quotient bit stages
  for (genvar i = 0; i < K; i++) begin : g_step
    cau_div_step #(.OPW(OPW)) u_step_re (
      .clk    (clk),
      .en     (en),
      .den    (den_p[i]),
      .p      (p_re[i]),
      .lq     (lq_re[i]),
      .p_out  (p_re[i+1]),
      .lq_out (lq_re[i+1])
    );

    cau_div_step #(.OPW(OPW)) u_step_im (
      .clk    (clk),
      .en     (en),
      .den    (den_p[i]),
      .p      (p_im[i]),
      .lq     (lq_im[i]),
      .p_out  (p_im[i+1]),
      .lq_out (lq_im[i+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_p[i+1].vld <= 1'b0;
      end else if (en) begin
        tag_p[i+1].vld <= tag_p[i].vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_p[i+1].is_div <= tag_p[i].is_div;
        tag_p[i+1].neg_re <= tag_p[i].neg_re;
        tag_p[i+1].neg_im <= tag_p[i].neg_im;
        tag_p[i+1].res    <= tag_p[i].res;
        den_p[i+1]        <= den_p[i];
        big_re_p[i+1]     <= big_re_p[i];
        big_im_p[i+1]     <= big_im_p[i];
      end
    end
  end

  assign tag_out = tag_p[K];
  assign q_re    = lq_re[K];
  assign q_im    = lq_im[K];
  assign big_re  = big_re_p[K];
  assign big_im  = big_im_p[K];

endmodule

### rtl/core/complex_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply and divide on signed fixed-point operands
// (FRAC_BITS fraction bits, min(WORD_BITS,32) significant bits, results
// sign-extended to 32 bits and saturated). The unit takes one word per
// clock and returns one result word per input word, in order. Every word
// goes through the same pipe: three front stages for products, sums
// and shift/saturate, one divider range check stage, one stage per
// quotient bit of the divider, and the output register. A stalled output
// holds the whole pipe. A divide by zero returns zero parts with div_zero
// set; products round toward minus infinity, quotients toward zero.
// ---------------------------------------------------------------------------
module complex_arithmetic_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  cau_in_if.sink     in_ch,
  cau_out_if.source  out_ch
);

  localparam int OPW = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int PW  = 2 * OPW;
  localparam int K   = OPW + 1;
  localparam int FW  = cau_pkg::FLD_W;

  // Pipe advances whenever the output register is free or being drained
  logic adv;
  logic out_vld_r;
  cau_pkg::res_t res_r, res_nxt;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Operands: low OPW bits, sign-extended inside the pipe
  logic signed [OPW-1:0] ar, ai, br, bi;
  assign ar = in_ch.a_real[OPW-1:0];
  assign ai = in_ch.a_imag[OPW-1:0];
  assign br = in_ch.b_real[OPW-1:0];
  assign bi = in_ch.b_imag[OPW-1:0];

  cau_pkg::tag_t fr_tag, dv_tag;
  logic [PW-1:0] mag_re, mag_im, den;
  logic [K-1:0]  q_re, q_im;
  logic          big_re, big_im;

  cau_front #(.OPW(OPW), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .in_vld (in_ch.valid),
    .cmd    (cau_pkg::cmd_t'(in_ch.cmd)),
    .ar     (ar),
    .ai     (ai),
    .br     (br),
    .bi     (bi),
    .tag    (fr_tag),
    .mag_re (mag_re),
    .mag_im (mag_im),
    .den    (den)
  );

  cau_divider #(.OPW(OPW), .FRAC_BITS(FRAC_BITS)) u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .tag_in  (fr_tag),
    .mag_re  (mag_re),
    .mag_im  (mag_im),
    .den     (den),
    .tag_out (dv_tag),
    .q_re    (q_re),
    .q_im    (q_im),
    .big_re  (big_re),
    .big_im  (big_im)
  );

  // Apply sign and saturate one quotient part; returns {ov, value}
  function automatic logic [OPW:0] div_pack(input logic [K-1:0] q,
                                            input logic big, input logic neg);
    logic           ov;
    logic [OPW-1:0] v;
    if (neg) begin
      ov = big | q[OPW] | (q[OPW-1] & (|q[OPW-2:0]));
      v  = ov ? {1'b1, {(OPW-1){1'b0}}} : (~q[OPW-1:0] + 1'b1);
    end else begin
      ov = big | q[OPW] | q[OPW-1];
      v  = ov ? {1'b0, {(OPW-1){1'b1}}} : q[OPW-1:0];
    end
    return {ov, v};
  endfunction

  logic [OPW:0]          pk_re, pk_im;
  logic signed [OPW-1:0] dv_v_re, dv_v_im;

  always_comb begin
    pk_re   = div_pack(q_re, big_re, dv_tag.neg_re);
    pk_im   = div_pack(q_im, big_im, dv_tag.neg_im);
    dv_v_re = pk_re[OPW-1:0];
    dv_v_im = pk_im[OPW-1:0];
    if (dv_tag.is_div) begin
      res_nxt.res_real = FW'(dv_v_re);
      res_nxt.res_imag = FW'(dv_v_im);
      res_nxt.overflow = pk_re[OPW] | pk_im[OPW];
      res_nxt.div_zero = 1'b0;
    end else begin
      res_nxt = dv_tag.res;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_tag.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.res_real = res_r.res_real;
  assign out_ch.res_imag = res_r.res_imag;
  assign out_ch.overflow = res_r.overflow;
  assign out_ch.div_zero = res_r.div_zero;

`ifndef ASSERT_OFF
  localparam logic [FW-1:0] SAT_POS = FW'((64'd1 << (OPW-1)) - 64'd1);
  localparam logic [FW-1:0] SAT_NEG = ~SAT_POS;

  // zero divisor word carries zero parts and no overflow
  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.div_zero |->
      out_ch.res_real == '0 && out_ch.res_imag == '0 && !out_ch.overflow)
    else $error("div_zero word with nonzero parts or overflow");

  // overflow means at least one part sits at a saturation limit
  a_ov_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.overflow |->
      out_ch.res_real == SAT_POS || out_ch.res_real == SAT_NEG ||
      out_ch.res_imag == SAT_POS || out_ch.res_imag == SAT_NEG)
    else $error("overflow without a saturated part");

  // pipe is empty after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");
`endif

endmodule

### verif/cau_tb_if.sv
// ---------------------------------------------------------------------------
// cau_tb_pkg
// Testbench types; the channel interfaces come from the RTL (cau_if.sv).
// ---------------------------------------------------------------------------
package cau_tb_pkg;

  // One operand word as the testbench records it
  typedef struct {
    cau_pkg::cmd_t op;
    logic [31:0]   ar, ai, br, bi;
  } operand_word_t;
endpackage

### verif/complex_arithmetic_unit_tb.sv
// ---------------------------------------------------------------------------
// complex_arithmetic_unit_tb
// Drives operand words with random gaps and output stalls, predicts each
// complex add/sub/mul/div result in fixed point and checks results in order.
// ---------------------------------------------------------------------------
module complex_arithmetic_unit_tb;

  localparam int FRAC = 16;
  localparam longint QCAP = 64'h1_0000_0000;

  // Clamp a signed value given as sign and magnitude
  function automatic logic [31:0] clamp_part(bit neg, logic [63:0] mag, ref bit ov);
    logic [63:0] lim;
    lim = 64'h7FFF_FFFF;
    if (!neg && mag > lim) begin
      mag = lim;
      ov = 1;
    end
    if (neg && mag > lim + 1) begin
      mag = lim + 1;
      ov = 1;
    end
    return neg ? 32'(-mag) : mag[31:0];
  endfunction

  function automatic logic [31:0] clamp_sum(longint s, ref bit ov);
    return clamp_part(s < 0, s < 0 ? 64'(-s) : 64'(s), ov);
  endfunction

  // Floor shift of a wrapped 64-bit sum
  function automatic logic [31:0] floor_shift(logic [63:0] s, ref bit ov);
    bit neg;
    logic [63:0] mag;
    neg = s[63] && s != 64'h8000_0000_0000_0000;
    mag = neg ? -s : s;
    mag = neg ? (mag + 64'hFFFF) >> FRAC : mag >> FRAC;
    return clamp_part(neg && mag != 0, mag, ov);
  endfunction

  // Fixed-point quotient of a wrapped sum, truncated toward zero
  function automatic logic [31:0] fix_quot(logic [63:0] s, logic [63:0] den, ref bit ov);
    bit neg;
    logic [63:0] mag, q, r;
    neg = s[63] && s != 64'h8000_0000_0000_0000;
    mag = neg ? -s : s;
    q = mag / den;
    r = mag % den;
    if (q > QCAP) q = QCAP;
    for (int i = 0; i < FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1;
      end
      if (q > QCAP) q = QCAP;
    end
    return clamp_part(neg && q != 0, q, ov);
  endfunction

  function automatic cau_pkg::res_t complex_result(cau_tb_pkg::operand_word_t w);
    cau_pkg::res_t r;
    bit ov;
    longint ar, ai, br, bi;
    logic [63:0] re, im, den;
    ov = 0;
    r = '0;
    ar = longint'(signed'(w.ar));
    ai = longint'(signed'(w.ai));
    br = longint'(signed'(w.br));
    bi = longint'(signed'(w.bi));
    case (w.op)
      cau_pkg::CMD_ADD: begin
        r.res_real = clamp_sum(ar + br, ov);
        r.res_imag = clamp_sum(ai + bi, ov);
      end
      cau_pkg::CMD_SUB: begin
        r.res_real = clamp_sum(ar - br, ov);
        r.res_imag = clamp_sum(ai - bi, ov);
      end
      cau_pkg::CMD_MUL: begin
        re = 64'(ar * br) - 64'(ai * bi);
        im = 64'(ar * bi) + 64'(ai * br);
        r.res_real = floor_shift(re, ov);
        r.res_imag = floor_shift(im, ov);
      end
      default: begin
        den = 64'(br * br) + 64'(bi * bi);
        if (den == 0) begin
          r.div_zero = 1;
        end else begin
          re = 64'(ar * br) + 64'(ai * bi);
          im = 64'(ai * br) - 64'(ar * bi);
          r.res_real = fix_quot(re, den, ov);
          r.res_imag = fix_quot(im, den, ov);
        end
      end
    endcase
    r.overflow = ov;
    return r;
  endfunction

  // Scoreboard: pending expected results, oldest first
  class result_board;
    cau_pkg::res_t pending[$];
    int errors;

    function void note_word(cau_tb_pkg::operand_word_t w);
      pending.push_back(complex_result(w));
    endfunction

    function void check_result(cau_pkg::res_t got);
      cau_pkg::res_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.res_real !== exp_r.res_real || got.res_imag !== exp_r.res_imag ||
          got.overflow !== exp_r.overflow || got.div_zero !== exp_r.div_zero) begin
        $display("%0t: mismatch expected re=%h im=%h ov=%b dz=%b got re=%h im=%h ov=%b dz=%b",
                 $time, exp_r.res_real, exp_r.res_imag, exp_r.overflow, exp_r.div_zero,
                 got.res_real, got.res_imag, got.overflow, got.div_zero);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  cau_in_if  in_ch();
  cau_out_if out_ch();
  result_board board = new();
  int send_gap_pct, stall_pct;
  bit long_hold;
  int cycles;

  complex_arithmetic_unit DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #1 clk = ~clk;

  // Sample accepted words at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      cau_tb_pkg::operand_word_t w;
      w.op = cau_pkg::cmd_t'(in_ch.cmd);
      w.ar = in_ch.a_real;
      w.ai = in_ch.a_imag;
      w.br = in_ch.b_real;
      w.bi = in_ch.b_imag;
      board.note_word(w);
    end
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result({out_ch.res_real, out_ch.res_imag, out_ch.overflow, out_ch.div_zero});
  end

  // Receiver stalls, with an occasional long hold-off
  always @(negedge clk) begin
    if (long_hold) out_ch.ready <= 0;
    else out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [31:0] rand_part();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(signed'($urandom_range(8 << 16)) - (4 << 16));
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  // Offer one word and hold it until accepted
  task automatic send_word(cau_pkg::cmd_t op, logic [31:0] ar, ai, br, bi);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.cmd <= op;
    in_ch.a_real <= ar;
    in_ch.a_imag <= ai;
    in_ch.b_real <= br;
    in_ch.b_imag <= bi;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++)
      send_word(cau_pkg::cmd_t'($urandom_range(3)), rand_part(), rand_part(), rand_part(),
                rand_part());
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.cmd = cau_pkg::CMD_ADD;
    in_ch.a_real = 0;
    in_ch.a_imag = 0;
    in_ch.b_real = 0;
    in_ch.b_imag = 0;
    out_ch.ready = 0;
    send_gap_pct = 0;
    stall_pct = 0;
    long_hold = 0;
    cycles = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: extremes, each operation, saturation, divide by zero
    send_word(cau_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    send_word(cau_pkg::CMD_ADD, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0);
    send_word(cau_pkg::CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    send_word(cau_pkg::CMD_SUB, 32'h0003_0000, 32'h0, 32'h0001_8000, 32'h0000_4000);
    send_word(cau_pkg::CMD_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
    send_word(cau_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(cau_pkg::CMD_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(cau_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);
    send_word(cau_pkg::CMD_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
    send_word(cau_pkg::CMD_DIV, 32'h0006_0000, 32'h0002_0000, 32'h0002_0000, 32'h0);
    send_word(cau_pkg::CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0);
    send_word(cau_pkg::CMD_DIV, 32'hFFFF_FFFF, 32'h0, 32'h0003_0000, 32'h0001_0000);
    send_word(cau_pkg::CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(cau_pkg::CMD_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
    send_random(16);

    // Long output hold-off while input keeps coming
    fork
      begin
        long_hold = 1;
        repeat (200) @(negedge clk);
        long_hold = 0;
      end
      send_random(80);
    join
    drain();

    // Random phases: none, sender gaps, receiver stalls, both
    send_random(150);
    send_gap_pct = 76;
    send_random(150);
    drain();
    send_gap_pct = 0;
    stall_pct = 76;
    send_random(150);
    send_gap_pct = 12;
    stall_pct = 12;
    send_random(150);
    stall_pct = 0;
    send_gap_pct = 0;
    drain();
    repeat (60) @(negedge clk);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
